FILE: sv/toeq_pkg.sv
// shared types and constants for the time-ordered event queue
// no dependencies
package toeq_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int JOB_W = 16;
  localparam int KIND_W = 4;
  localparam int TIME_W = 31;
  localparam int CNT_W = 5;

  localparam logic [KIND_W-1:0] START_KIND = KIND_W'(1);
  localparam logic [KIND_W-1:0] END_KIND = KIND_W'(8);
  localparam logic [TIME_W-1:0] END_TIME = TIME_W'(10000);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(2);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [JOB_W-1:0] job;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] etime;
  } entry_t;

  // broadcast to every cell for the current item
  typedef struct packed {
    logic push;
    logic pop;
    entry_t entry;
  } cell_ctl_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic valid;
    logic greater;
    entry_t entry;
  } cell_link_t;

endpackage

FILE: sv/toeq_cell.sv
// one slot of the sorted event chain
// depends on toeq_pkg
module toeq_cell (
  input  logic                clk,
  input  logic                rst,
  input  toeq_pkg::entry_t    rst_entry,
  input  logic                rst_valid,
  input  toeq_pkg::cell_ctl_t ctl,
  input  toeq_pkg::cell_link_t prev_link,
  input  toeq_pkg::cell_link_t next_link,
  output toeq_pkg::cell_link_t link
);

  logic valid;
  toeq_pkg::entry_t entry;
  logic greater;
  logic take_new;

  assign greater = valid && (entry.etime > ctl.entry.etime);
  assign take_new = prev_link.valid && !prev_link.greater && (greater || !valid);

  assign link.valid = valid;
  assign link.greater = greater;
  assign link.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= rst_valid;
      entry <= rst_entry;
    end else if (ctl.push) begin
      valid <= valid || prev_link.valid;
      if (prev_link.greater) begin
        entry <= prev_link.entry;
      end else if (take_new) begin
        entry <= ctl.entry;
      end
    end else if (ctl.pop) begin
      valid <= next_link.valid;
      entry <= next_link.entry;
    end
  end

endmodule

FILE: sv/time_ordered_event_queue_core.sv
// top level of the time-ordered event queue: chain of sorted cells, count and result register
// depends on toeq_pkg and toeq_cell
//
// Takes one item (push or pop) in every clock cycle; busy stays low. The result of an
// item appears on the result ports with done high in the cycle after start, for that one
// cycle only, and must be captured then. A push shifts every later event one cell along
// the chain in the same cycle, and a pop shifts the whole chain towards the head, so the
// earliest event always sits in the first cell. After reset the queue holds a start event
// at time 0 and an end event at time 10000; equal times leave in arrival order.
module time_ordered_event_queue_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [toeq_pkg::JOB_W-1:0]    job_number,
  input  logic [toeq_pkg::KIND_W-1:0]   event_kind,
  input  logic [toeq_pkg::TIME_W-1:0]   event_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [toeq_pkg::CNT_W-1:0]    cfg_data,
  output logic                          done,
  output logic                          popped_valid,
  output logic [toeq_pkg::JOB_W-1:0]    out_job_number,
  output logic [toeq_pkg::KIND_W-1:0]   out_event_kind,
  output logic [toeq_pkg::TIME_W-1:0]   out_event_time,
  output logic                          push_dropped,
  output logic                          pop_empty,
  output logic [toeq_pkg::CNT_W-1:0]    entries_left
);

  logic [toeq_pkg::CNT_W-1:0] capacity_limit;
  logic [toeq_pkg::CNT_W-1:0] entry_count;
  logic [toeq_pkg::CNT_W-1:0] entry_count_next;
  logic [toeq_pkg::CNT_W-1:0] eff_limit;
  logic is_pop;
  logic do_push;
  logic do_pop;
  logic drop;
  logic empty;
  toeq_pkg::cell_ctl_t ctl;
  toeq_pkg::cell_link_t links [toeq_pkg::STORE_DEPTH];
  toeq_pkg::cell_link_t head_prev;
  toeq_pkg::cell_link_t tail_next;
  toeq_pkg::entry_t start_entry;
  toeq_pkg::entry_t end_entry;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  assign is_pop = (toeq_pkg::cmd_t'(cmd) == toeq_pkg::CMD_POP);
  assign eff_limit = (capacity_limit > toeq_pkg::DEPTH_CNT) ? toeq_pkg::DEPTH_CNT
                                                            : capacity_limit;
  assign drop = (entry_count >= eff_limit) || (entry_count >= toeq_pkg::DEPTH_CNT);
  assign empty = (entry_count == '0);
  assign do_push = start && !is_pop && !drop;
  assign do_pop = start && is_pop && !empty;

  assign ctl.push = do_push;
  assign ctl.pop = do_pop;
  assign ctl.entry.job = job_number;
  assign ctl.entry.kind = event_kind;
  assign ctl.entry.etime = event_time;

  assign head_prev.valid = 1'b1;
  assign head_prev.greater = 1'b0;
  assign head_prev.entry = '0;
  assign tail_next = '0;

  assign start_entry.job = '0;
  assign start_entry.kind = toeq_pkg::START_KIND;
  assign start_entry.etime = '0;
  assign end_entry.job = '0;
  assign end_entry.kind = toeq_pkg::END_KIND;
  assign end_entry.etime = toeq_pkg::END_TIME;

  for (genvar i = 0; i < toeq_pkg::STORE_DEPTH; i++) begin : g_cell
    toeq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .rst_entry ((i == 0) ? start_entry : end_entry),
      .rst_valid ((i < 2) ? 1'b1 : 1'b0),
      .ctl       (ctl),
      .prev_link ((i == 0) ? head_prev : links[(i == 0) ? 0 : i - 1]),
      .next_link ((i == toeq_pkg::STORE_DEPTH - 1) ? tail_next
                  : links[(i == toeq_pkg::STORE_DEPTH - 1) ? i : i + 1]),
      .link      (links[i])
    );
  end

  always_comb begin
    entry_count_next = entry_count;
    if (do_push) begin
      entry_count_next = entry_count + 1'b1;
    end else if (do_pop) begin
      entry_count_next = entry_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= toeq_pkg::CAP_RESET;
      entry_count <= toeq_pkg::RESET_COUNT;
      done <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_limit <= cfg_data;
      end
      entry_count <= entry_count_next;
      done <= start;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (start) begin
      popped_valid <= do_pop;
      push_dropped <= !is_pop && drop;
      pop_empty <= is_pop && empty;
      entries_left <= entry_count_next;
      if (do_pop) begin
        out_job_number <= links[0].entry.job;
        out_event_kind <= links[0].entry.kind;
        out_event_time <= links[0].entry.etime;
      end else begin
        out_job_number <= '0;
        out_event_kind <= '0;
        out_event_time <= '0;
      end
    end
  end

endmodule

FILE: test/toeq_checker.sv
// checker for the time-ordered event queue: predicts each result from accepted items
// and register writes, and compares it field by field with what the block returns
// depends on toeq_pkg
module toeq_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cmd,
  input  logic [toeq_pkg::JOB_W-1:0]    job_number,
  input  logic [toeq_pkg::KIND_W-1:0]   event_kind,
  input  logic [toeq_pkg::TIME_W-1:0]   event_time,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [toeq_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          done,
  input  logic                          popped_valid,
  input  logic [toeq_pkg::JOB_W-1:0]    out_job_number,
  input  logic [toeq_pkg::KIND_W-1:0]   out_event_kind,
  input  logic [toeq_pkg::TIME_W-1:0]   out_event_time,
  input  logic                          push_dropped,
  input  logic                          pop_empty,
  input  logic [toeq_pkg::CNT_W-1:0]    entries_left,
  output int                            fail_count,
  output int                            outstanding
);

  typedef struct packed {
    logic                        popped;
    logic [toeq_pkg::JOB_W-1:0]  job;
    logic [toeq_pkg::KIND_W-1:0] kind;
    logic [toeq_pkg::TIME_W-1:0] etime;
    logic                        dropped;
    logic                        empty;
    logic [toeq_pkg::CNT_W-1:0]  left;
  } outcome_t;

  toeq_pkg::entry_t           sorted_events [toeq_pkg::STORE_DEPTH];
  int                         held;
  logic [toeq_pkg::CNT_W-1:0] capacity;
  outcome_t                   awaited [$];

  function automatic outcome_t queue_step(toeq_pkg::cmd_t op, toeq_pkg::entry_t ev);
    outcome_t r;
    int pos;
    int limit;
    int i;
    r = '0;
    limit = (capacity > toeq_pkg::DEPTH_CNT) ? toeq_pkg::STORE_DEPTH : int'(capacity);
    if (op == toeq_pkg::CMD_PUSH) begin
      if (held >= limit) begin
        r.dropped = 1'b1;
      end else begin
        // equal times stay in arrival order
        pos = held;
        while (pos > 0 && sorted_events[pos-1].etime > ev.etime) begin
          sorted_events[pos] = sorted_events[pos-1];
          pos--;
        end
        sorted_events[pos] = ev;
        held++;
      end
    end else if (held == 0) begin
      r.empty = 1'b1;
    end else begin
      r.popped = 1'b1;
      r.job = sorted_events[0].job;
      r.kind = sorted_events[0].kind;
      r.etime = sorted_events[0].etime;
      for (i = 1; i < held; i++) sorted_events[i-1] = sorted_events[i];
      held--;
    end
    r.left = toeq_pkg::CNT_W'(held);
    return r;
  endfunction

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    toeq_pkg::entry_t ev;
    int i;
    if (rst) begin
      for (i = 0; i < toeq_pkg::STORE_DEPTH; i++) sorted_events[i] = '0;
      sorted_events[0] = '{job: '0, kind: toeq_pkg::START_KIND, etime: '0};
      sorted_events[1] = '{job: '0, kind: toeq_pkg::END_KIND, etime: toeq_pkg::END_TIME};
      held = int'(toeq_pkg::RESET_COUNT);
      capacity = toeq_pkg::CAP_RESET;
      awaited.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (awaited.size() == 0) begin
          $display("%0t result with no item waiting: expected none actual left %0d",
                   $time, entries_left);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          compare_field("popped_valid", 32'(want.popped), 32'(popped_valid));
          compare_field("out_job_number", 32'(want.job), 32'(out_job_number));
          compare_field("out_event_kind", 32'(want.kind), 32'(out_event_kind));
          compare_field("out_event_time", 32'(want.etime), 32'(out_event_time));
          compare_field("push_dropped", 32'(want.dropped), 32'(push_dropped));
          compare_field("pop_empty", 32'(want.empty), 32'(pop_empty));
          compare_field("entries_left", 32'(want.left), 32'(entries_left));
        end
      end
      if (start && !busy) begin
        ev = '{job: job_number, kind: event_kind, etime: event_time};
        awaited.push_back(queue_step(toeq_pkg::cmd_t'(cmd), ev));
      end
      // a register write takes effect for the next item
      if (cfg_valid && cfg_ready) capacity = cfg_data;
    end
    outstanding = awaited.size();
  end

endmodule

FILE: test/testbench.sv
// top of the time-ordered event queue test: drives items and capacity writes with
// bursty timing, runs a watchdog and prints the verdict
// depends on toeq_pkg, time_ordered_event_queue_core and toeq_checker
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        cmd;
  logic [toeq_pkg::JOB_W-1:0]  job_number;
  logic [toeq_pkg::KIND_W-1:0] event_kind;
  logic [toeq_pkg::TIME_W-1:0] event_time;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [toeq_pkg::CNT_W-1:0]  cfg_data;
  logic                        done;
  logic                        popped_valid;
  logic [toeq_pkg::JOB_W-1:0]  out_job_number;
  logic [toeq_pkg::KIND_W-1:0] out_event_kind;
  logic [toeq_pkg::TIME_W-1:0] out_event_time;
  logic                        push_dropped;
  logic                        pop_empty;
  logic [toeq_pkg::CNT_W-1:0]  entries_left;
  int                          fail_count;
  int                          outstanding;
  int                          burst_left;
  int                          quiet_cycles;

  time_ordered_event_queue_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .job_number(job_number), .event_kind(event_kind), .event_time(event_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .popped_valid(popped_valid), .out_job_number(out_job_number),
    .out_event_kind(out_event_kind), .out_event_time(out_event_time),
    .push_dropped(push_dropped), .pop_empty(pop_empty), .entries_left(entries_left)
  );

  toeq_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .job_number(job_number), .event_kind(event_kind), .event_time(event_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .popped_valid(popped_valid), .out_job_number(out_job_number),
    .out_event_kind(out_event_kind), .out_event_time(out_event_time),
    .push_dropped(push_dropped), .pop_empty(pop_empty), .entries_left(entries_left),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called just after a falling edge; returns just after the falling edge past acceptance
  task automatic send_item(toeq_pkg::cmd_t op, logic [toeq_pkg::JOB_W-1:0] job,
                           logic [toeq_pkg::KIND_W-1:0] kind,
                           logic [toeq_pkg::TIME_W-1:0] etime);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    start <= 1'b1;
    cmd <= op;
    job_number <= job;
    event_kind <= kind;
    event_time <= etime;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // hold off until every result has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_capacity(logic [toeq_pkg::CNT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(int push_pct);
    toeq_pkg::cmd_t op;
    logic [toeq_pkg::TIME_W-1:0] etime;
    op = ($urandom_range(99) < push_pct) ? toeq_pkg::CMD_PUSH : toeq_pkg::CMD_POP;
    case ($urandom_range(9))
      0: etime = '0;
      1: etime = '1;
      2, 3, 4, 5: etime = toeq_pkg::TIME_W'($urandom_range(15));
      6: etime = toeq_pkg::END_TIME;
      default: etime = toeq_pkg::TIME_W'($urandom);
    endcase
    send_item(op, toeq_pkg::JOB_W'($urandom), toeq_pkg::KIND_W'($urandom), etime);
  endtask

  initial begin
    logic [toeq_pkg::CNT_W-1:0] capacities [8];
    int n;
    int push_pct;
    rst = 1'b1;
    start = 1'b0;
    cmd = toeq_pkg::CMD_PUSH;
    job_number = '0;
    event_kind = '0;
    event_time = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // preloaded start and end events, then an empty pop
    repeat (3) send_item(toeq_pkg::CMD_POP, '0, '0, '0);
    send_item(toeq_pkg::CMD_PUSH, '1, '1, '1);
    send_item(toeq_pkg::CMD_PUSH, '0, '0, '0);
    send_item(toeq_pkg::CMD_PUSH, 16'hA5A5, 4'd5, 31'd100);
    send_item(toeq_pkg::CMD_PUSH, 16'h5A5A, 4'd10, 31'd100);
    send_item(toeq_pkg::CMD_PUSH, 16'd1, 4'd3, 31'd100);
    send_item(toeq_pkg::CMD_PUSH, 16'd2, 4'd6, 31'd50);
    send_item(toeq_pkg::CMD_PUSH, 16'd3, 4'd9, 31'h4000_0000);
    send_item(toeq_pkg::CMD_PUSH, 16'd4, 4'd12, 31'd7);
    send_item(toeq_pkg::CMD_PUSH, 16'd5, 4'd2, 31'd100);
    send_item(toeq_pkg::CMD_PUSH, 16'd6, 4'd4, 31'h2AAA_AAAA);
    // full at the reset capacity
    send_item(toeq_pkg::CMD_PUSH, 16'd7, 4'd7, 31'd1);
    repeat (11) send_item(toeq_pkg::CMD_POP, '1, '1, '1);

    capacities = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd1, 5'd17, 5'd2, toeq_pkg::CAP_RESET};
    capacities[6] = toeq_pkg::CNT_W'($urandom_range(2, 16));
    foreach (capacities[p]) begin
      write_capacity(capacities[p]);
      n = (capacities[p] < 2) ? 30 : 120;
      push_pct = 50;
      for (int k = 0; k < n; k++) begin
        if (k % 30 == 0) push_pct = $urandom_range(25, 80);
        random_item(push_pct);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/toeq_pkg.sv
sv/toeq_cell.sv
sv/time_ordered_event_queue_core.sv
test/toeq_checker.sv
test/testbench.sv
